@@ sv/assert_macros.svh @@
// Assertion macros for the hash engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define SHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define SHA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SHA_ASSERT(lbl, prop, msg)
`define SHA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ sv/sha_pkg.sv @@
// Types, constants and tables for the SHA-1 / SHA-256 hash engine.
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_LEN,
        ST_OUT
    } state_t;

    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_DATA   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic ALG_SHA1   = 1'b0;
    localparam logic ALG_SHA256 = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [6:0] LAST_RND_SHA1   = 7'd79;
    localparam logic [6:0] LAST_RND_SHA256 = 7'd63;
    localparam logic [2:0] LAST_IDX_SHA1   = 3'd4;
    localparam logic [2:0] LAST_IDX_SHA256 = 3'd7;

    localparam logic [31:0] K1_0 = 32'h5A827999;
    localparam logic [31:0] K1_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K1_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K1_3 = 32'hCA62C1D6;

    typedef logic [7:0][31:0] chain_t;

    function automatic chain_t iv(input logic alg);
        chain_t r;
        if (alg == ALG_SHA256)
        begin
            r = {32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
                 32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};
        end
        else
        begin
            r = {32'h0, 32'h0, 32'h0, 32'hc3d2e1f0,
                 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
        end
        return r;
    endfunction

    function automatic logic [31:0] k256(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

@@ sv/sha_round.sv @@
// Shared round unit: one SHA-1 or SHA-256 round plus the next schedule word.
module sha_round
(
    input  logic                alg,
    input  logic [6:0]          rnd,
    input  sha_pkg::chain_t     v,
    input  logic [15:0][31:0]   w,
    output sha_pkg::chain_t     v_next,
    output logic [31:0]         w_new
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] f1, k1, nv1, x1;
    logic [31:0] big0, big1, ch, maj, tmp1, tmp2;
    logic [31:0] s0, s1;

    always_comb
    begin
        // SHA-1 round
        priority if (rnd < 7'd20)
        begin
            f1 = v[3] ^ (v[1] & (v[2] ^ v[3]));
            k1 = sha_pkg::K1_0;
        end
        else if (rnd < 7'd40)
        begin
            f1 = v[1] ^ v[2] ^ v[3];
            k1 = sha_pkg::K1_1;
        end
        else if (rnd < 7'd60)
        begin
            f1 = (v[1] & v[2]) | (v[3] & (v[1] | v[2]));
            k1 = sha_pkg::K1_2;
        end
        else
        begin
            f1 = v[1] ^ v[2] ^ v[3];
            k1 = sha_pkg::K1_3;
        end
        nv1 = rotr(v[0], 27) + f1 + v[4] + k1 + w[0];
        x1  = w[13] ^ w[8] ^ w[2] ^ w[0];

        // SHA-256 round
        big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
        ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
        big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
        maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        tmp1 = v[7] + big1 + ch + sha_pkg::k256(rnd[5:0]) + w[0];
        tmp2 = big0 + maj;
        s1   = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
        s0   = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);

        if (alg == sha_pkg::ALG_SHA256)
        begin
            v_next = {v[6], v[5], v[4], v[3] + tmp1, v[2], v[1], v[0], tmp1 + tmp2};
            w_new  = s1 + w[9] + s0 + w[0];
        end
        else
        begin
            v_next = {v[7], v[6], v[5], v[3], v[2], rotr(v[1], 2), v[0], nv1};
            w_new  = {x1[30:0], x1[31]};
        end
    end

endmodule

@@ sv/sha1_sha256_hash_engine.sv @@
// Top level of the SHA-1 / SHA-256 byte-stream hash engine.
//
// s_* takes one request word: s_tuser is the request (start, data, finish),
// s_tdata the message byte. cfg_* writes the algorithm select (0 SHA-1,
// 1 SHA-256); write it only while the engine is idle.
// A start or a data byte that does not fill the block leaves the engine idle.
// The 64th byte of a block runs the compression: 80 (SHA-1) or 64 (SHA-256)
// rounds, one per cycle through the shared round unit, then the chain add.
// A finish takes a padding step, one or two compressions (two when fewer
// than 9 bytes of the block remain, with the length block laid in between
// them), then presents 5 or 8 digest words on m_*, index 0 first, with
// m_tlast on the final word. The engine holds each word while m_tready is
// low and accepts no request until the last word is taken.
// Reset loads the SHA-1 initial vector, clears the byte count and selects
// SHA-1.
`include "assert_macros.svh"

module sha1_sha256_hash_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast,   // last_word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // hash_algorithm
);

    sha_pkg::state_t   state_reg, state_next;
    logic              alg_reg;
    sha_pkg::chain_t   chain_reg;
    sha_pkg::chain_t   v_reg;
    logic [15:0][31:0] blk_reg;
    logic [60:0]       count_reg;
    logic [6:0]        rnd_reg;
    logic [2:0]        idx_reg;
    logic              fin_reg;
    logic              extra_reg;

    sha_pkg::chain_t   v_next;
    logic [31:0]       w_new;
    logic              in_acc, out_acc, last_rnd, last_idx, full_blk;
    logic [5:0]        pos;
    logic [63:0]       bit_len;

    sha_round u_round
    (
        .alg    (alg_reg),
        .rnd    (rnd_reg),
        .v      (v_reg),
        .w      (blk_reg),
        .v_next (v_next),
        .w_new  (w_new)
    );

    assign pos      = count_reg[5:0];
    assign bit_len  = {count_reg, 3'b000};
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign full_blk = (s_tuser == sha_pkg::REQ_DATA) && (pos == 6'd63);
    assign last_rnd = rnd_reg == ((alg_reg == sha_pkg::ALG_SHA256) ?
                      sha_pkg::LAST_RND_SHA256 : sha_pkg::LAST_RND_SHA1);
    assign last_idx = idx_reg == ((alg_reg == sha_pkg::ALG_SHA256) ?
                      sha_pkg::LAST_IDX_SHA256 : sha_pkg::LAST_IDX_SHA1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (in_acc && full_blk)
                    state_next = sha_pkg::ST_ROUND;
                else if (in_acc && s_tuser == sha_pkg::REQ_FINISH)
                    state_next = sha_pkg::ST_PAD;
            end
            sha_pkg::ST_PAD:   state_next = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND:
            begin
                if (last_rnd)
                    state_next = sha_pkg::ST_ADD;
            end
            sha_pkg::ST_ADD:
            begin
                priority if (fin_reg && extra_reg)
                    state_next = sha_pkg::ST_LEN;
                else if (fin_reg)
                    state_next = sha_pkg::ST_OUT;
                else
                    state_next = sha_pkg::ST_IDLE;
            end
            sha_pkg::ST_LEN:   state_next = sha_pkg::ST_ROUND;
            sha_pkg::ST_OUT:
            begin
                if (out_acc && last_idx)
                    state_next = sha_pkg::ST_IDLE;
            end
            default:           state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready  = state_reg == sha_pkg::ST_IDLE;
        m_tvalid  = state_reg == sha_pkg::ST_OUT;
        m_tlast   = last_idx;
        m_tdata   = {5'b00000, idx_reg, chain_reg[idx_reg]};
        cfg_ready = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            alg_reg   <= sha_pkg::ALG_SHA1;
            chain_reg <= sha_pkg::iv(sha_pkg::ALG_SHA1);
            v_reg     <= '0;
            count_reg <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            extra_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                alg_reg <= cfg_data;
            unique case (state_reg)
                sha_pkg::ST_IDLE:
                begin
                    rnd_reg <= '0;
                    idx_reg <= '0;
                    if (in_acc)
                    begin
                        unique case (s_tuser)
                            sha_pkg::REQ_START:
                            begin
                                chain_reg <= sha_pkg::iv(alg_reg);
                                count_reg <= '0;
                            end
                            sha_pkg::REQ_DATA:
                            begin
                                count_reg <= count_reg + 61'd1;
                                fin_reg   <= 1'b0;
                                v_reg     <= chain_reg;
                            end
                            sha_pkg::REQ_FINISH:
                            begin
                                fin_reg   <= 1'b1;
                                extra_reg <= pos >= 6'd56;
                                v_reg     <= chain_reg;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                sha_pkg::ST_ROUND:
                begin
                    v_reg   <= v_next;
                    rnd_reg <= rnd_reg + 7'd1;
                end
                sha_pkg::ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        if (i < 5 || alg_reg == sha_pkg::ALG_SHA256)
                            chain_reg[i] <= chain_reg[i] + v_reg[i];
                    end
                    for (int i = 0; i < 5; i++)
                        v_reg[i] <= chain_reg[i] + v_reg[i];
                    if (alg_reg == sha_pkg::ALG_SHA256)
                    begin
                        for (int i = 5; i < 8; i++)
                            v_reg[i] <= chain_reg[i] + v_reg[i];
                    end
                    else
                        v_reg[7:5] <= chain_reg[7:5];
                    rnd_reg <= '0;
                    if (fin_reg && !extra_reg)
                        count_reg <= '0;
                end
                sha_pkg::ST_LEN:
                begin
                    extra_reg <= 1'b0;
                end
                sha_pkg::ST_OUT:
                begin
                    if (out_acc)
                        idx_reg <= idx_reg + 3'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // block buffer: byte writes, padding, the schedule window shift and the length block
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (in_acc && s_tuser == sha_pkg::REQ_DATA)
                    blk_reg[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] <= s_tdata;
            end
            sha_pkg::ST_PAD:
            begin
                // the last two words take the length when it fits in this block
                for (int b = 0; b < 64; b++)
                begin
                    if (b == int'(pos))
                        blk_reg[b / 4][(3 - b % 4) * 8 +: 8] <= sha_pkg::PAD_BYTE;
                    else if (b > int'(pos) && (b < 56 || pos >= 6'd56))
                        blk_reg[b / 4][(3 - b % 4) * 8 +: 8] <= 8'h00;
                end
                if (pos < 6'd56)
                begin
                    blk_reg[14] <= bit_len[63:32];
                    blk_reg[15] <= bit_len[31:0];
                end
            end
            sha_pkg::ST_ROUND:
            begin
                blk_reg <= {w_new, blk_reg[15:1]};
            end
            sha_pkg::ST_LEN:
            begin
                blk_reg <= {bit_len[31:0], bit_len[63:32], {14{32'h0}}};
            end
            default:
            begin
            end
        endcase
    end

    `SHA_ASSERT(a_out_blocks_in, m_tvalid |-> !s_tready, "request taken while digest pending")
    `SHA_ASSERT(a_last_index, (m_tvalid && m_tlast) |-> (idx_reg == sha_pkg::LAST_IDX_SHA1 || idx_reg == sha_pkg::LAST_IDX_SHA256), "tlast on wrong word")
    `SHA_ASSERT(a_rnd_range, (state_reg == sha_pkg::ST_ROUND) |-> (rnd_reg <= sha_pkg::LAST_RND_SHA1), "round counter overrun")
    `SHA_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "config port not ready")

endmodule

@@ tb/sv/sha1_sha256_hash_engine_tb.sv @@
// Self-checking testbench for the SHA-1 / SHA-256 byte-stream hash engine.
`timescale 1ns / 1ps

module sha1_sha256_hash_engine_tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT = 600000;
    localparam int NO_KAT = -1;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    typedef struct {
        int          set_alg;   // -1: leave algorithm alone
        logic [1:0]  req;
        logic [7:0]  dbyte;
        int          kat;       // known digest, or NO_KAT
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic [1:0]  s_tuser = 2'b00;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [31:0] digest_word, [34:32] word_index
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    sha1_sha256_hash_engine dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // engine state as predicted
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    logic [60:0] nbytes;
    logic        alg;
    logic [31:0] digest_out [8];

    digest_word_t digest_q[$];
    int errors = 0;
    int cycles = 0;
    int snd_idle = 35;
    int rcv_idle = 68;
    bit hold_req = 0;
    int hold_left = 0;

    logic [31:0] kat_words [3][8];

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sha256_k(input int t);
        logic [31:0] k [64];
        k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
              32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
              32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
              32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
              32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
              32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
              32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
              32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
              32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
              32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
              32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
              32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
              32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction

    task automatic compress_block();
        logic [31:0] w [80];
        logic [31:0] v [8];
        logic [31:0] f, kc, t1, t2;
        for (int t = 0; t < 16; t++) w[t] = blk[t];
        for (int t = 0; t < 8; t++) v[t] = chain[t];
        if (alg == sha_pkg::ALG_SHA256)
        begin
            for (int t = 16; t < 64; t++)
                w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                     + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
            for (int t = 0; t < 64; t++)
            begin
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_k(t) + w[t];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int t = 0; t < 8; t++) chain[t] += v[t];
        end
        else
        begin
            for (int t = 16; t < 80; t++)
                w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
            for (int t = 0; t < 80; t++)
            begin
                if (t < 20)
                begin
                    f = v[3] ^ (v[1] & (v[2] ^ v[3])); kc = sha_pkg::K1_0;
                end
                else if (t < 40)
                begin
                    f = v[1] ^ v[2] ^ v[3]; kc = sha_pkg::K1_1;
                end
                else if (t < 60)
                begin
                    f = (v[1] & v[2]) | (v[3] & (v[1] | v[2])); kc = sha_pkg::K1_2;
                end
                else
                begin
                    f = v[1] ^ v[2] ^ v[3]; kc = sha_pkg::K1_3;
                end
                t1 = rotl(v[0], 5) + f + v[4] + kc + w[t];
                v[4] = v[3]; v[3] = v[2]; v[2] = rotl(v[1], 30); v[1] = v[0]; v[0] = t1;
            end
            for (int t = 0; t < 5; t++) chain[t] += v[t];
        end
    endtask

    task automatic put_byte(input int pos, input logic [7:0] b);
        blk[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
    endtask

    // advance the predicted engine by one request; nw digest words land in digest_out
    task automatic hash_request(input logic [1:0] req, input logic [7:0] b, output int nw);
        int pos;
        logic [63:0] bitlen;
        nw = 0;
        pos = int'(nbytes[5:0]);
        case (req)
            sha_pkg::REQ_START:
            begin
                for (int i = 0; i < 8; i++) chain[i] = '0;
                if (alg == sha_pkg::ALG_SHA256)
                    chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
                else
                    chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476,
                              32'hc3d2e1f0, 32'h0, 32'h0, 32'h0};
                nbytes = '0;
            end
            sha_pkg::REQ_DATA:
            begin
                put_byte(pos, b);
                nbytes = nbytes + 1'b1;
                if (pos == 63) compress_block();
            end
            sha_pkg::REQ_FINISH:
            begin
                bitlen = {nbytes, 3'b000};
                put_byte(pos, sha_pkg::PAD_BYTE);
                for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
                if (pos >= 56)
                begin
                    compress_block();
                    for (int i = 0; i < 14; i++) blk[i] = '0;
                end
                blk[14] = bitlen[63:32];
                blk[15] = bitlen[31:0];
                compress_block();
                nbytes = '0;
                nw = (alg == sha_pkg::ALG_SHA256) ? 8 : 5;
                for (int i = 0; i < 8; i++) digest_out[i] = chain[i];
            end
            default: ;  // unused code, ignored
        endcase
    endtask

    task automatic report(input string what, input logic [39:0] got, input logic [39:0] exp);
        $display("ERROR %0t: %s got %h expected %h", $time, what, got, exp);
        errors++;
    endtask

    // one request word through the slave side, predicted at acceptance
    task automatic send_req(input logic [1:0] req, input logic [7:0] b, input int kat);
        int nw;
        if ($urandom_range(0, 99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        hash_request(req, b, nw);
        for (int i = 0; i < nw; i++)
            digest_q.push_back('{(kat == NO_KAT) ? digest_out[i] : kat_words[kat][i],
                                 3'(i), i == nw - 1});
    endtask

    // wait until the engine has delivered everything and gone quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_alg(input logic a);
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        alg = a;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stalls, long hold-off on request, word checks
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sha1_sha256_hash_engine: mismatch");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_q.size() == 0)
                report("unexpected word", m_tdata, '0);
            else
            begin
                if (m_tdata[31:0] != digest_q[0].word)
                    report("digest_word", 40'(m_tdata[31:0]), 40'(digest_q[0].word));
                if (m_tdata[34:32] != digest_q[0].idx)
                    report("word_index", 40'(m_tdata[34:32]), 40'(digest_q[0].idx));
                if (m_tdata[39:35] != '0)
                    report("tdata pad", 40'(m_tdata[39:35]), '0);
                if (m_tlast != digest_q[0].last)
                    report("last_word", 40'(m_tlast), 40'(digest_q[0].last));
                void'(digest_q.pop_front());
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 0;
            hold_left = 400;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    initial
    begin
        stim_row_t rows [24];
        int len;
        bit skip_start, skip_finish;

        kat_words[0] = '{32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c,
                         32'h9cd0d89d, 32'h0, 32'h0, 32'h0};
        kat_words[1] = '{32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890,
                         32'hafd80709, 32'h0, 32'h0, 32'h0};
        kat_words[2] = '{32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
                         32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad};
        rows = '{
            // no start after reset: runs from the SHA-1 vector
            '{-1, sha_pkg::REQ_DATA, 8'h61, NO_KAT}, '{-1, sha_pkg::REQ_DATA, 8'h62, NO_KAT},
            '{-1, sha_pkg::REQ_DATA, 8'h63, NO_KAT}, '{-1, sha_pkg::REQ_FINISH, 8'h00, 0},
            // finish again chains from the digest
            '{-1, sha_pkg::REQ_FINISH, 8'h00, NO_KAT},
            '{-1, REQ_UNUSED, 8'hff, NO_KAT},
            '{-1, sha_pkg::REQ_START, 8'hff, NO_KAT}, '{-1, sha_pkg::REQ_FINISH, 8'hff, 1},
            '{-1, sha_pkg::REQ_DATA, 8'h00, NO_KAT}, '{-1, sha_pkg::REQ_DATA, 8'hff, NO_KAT},
            '{-1, sha_pkg::REQ_FINISH, 8'h00, NO_KAT},
            '{ 1, sha_pkg::REQ_START, 8'h00, NO_KAT}, '{-1, sha_pkg::REQ_DATA, 8'h61, NO_KAT},
            '{-1, sha_pkg::REQ_DATA, 8'h62, NO_KAT}, '{-1, sha_pkg::REQ_DATA, 8'h63, NO_KAT},
            '{-1, sha_pkg::REQ_FINISH, 8'h00, 2},
            '{-1, sha_pkg::REQ_START, 8'h00, NO_KAT}, '{-1, sha_pkg::REQ_DATA, 8'h80, NO_KAT},
            '{-1, sha_pkg::REQ_DATA, 8'h7f, NO_KAT}, '{-1, sha_pkg::REQ_FINISH, 8'h00, NO_KAT},
            // start under SHA-1 after SHA-256 clears the upper chain words
            '{ 0, sha_pkg::REQ_START, 8'h00, NO_KAT}, '{-1, sha_pkg::REQ_FINISH, 8'h00, 1},
            '{-1, sha_pkg::REQ_DATA, 8'h55, NO_KAT}, '{-1, sha_pkg::REQ_FINISH, 8'haa, NO_KAT}
        };

        alg = sha_pkg::ALG_SHA1;
        nbytes = '0;
        chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476,
                  32'hc3d2e1f0, 32'h0, 32'h0, 32'h0};
        for (int i = 0; i < 16; i++) blk[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
        begin
            if (rows[r].set_alg >= 0)
            begin
                drain();
                write_alg(rows[r].set_alg[0]);
            end
            send_req(rows[r].req, rows[r].dbyte, rows[r].kat);
        end

        for (int p = 0; p < 6; p++)
        begin
            drain();
            snd_idle = (p < 2) ? 35 : (p < 4) ? 68 : 0;
            rcv_idle = (p < 2) ? 68 : (p < 4) ? 35 : 0;
            // phase 2 leaves a message open, so the algorithm flips mid-message
            write_alg((p < 4) ? p[0] : 1'($urandom_range(0, 1)));
            if (p == 3) hold_req = 1;
            for (int s = 0; s < 2; s++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6, 7: len = $urandom_range(0, 3);
                    default:               len = $urandom_range(4, 9);
                endcase
                // a full block, then a finish that needs an extra block
                if (p == 1 && s == 1) len = 120;
                if (p == 3 && s == 0) len = 3;
                skip_start = ($urandom_range(0, 99) < 12) && !(p == 3 && s == 0);
                skip_finish = (p == 2 && s == 1) ||
                              (($urandom_range(0, 99) < 8) && !(p == 1 && s == 1));
                if (!skip_start) send_req(sha_pkg::REQ_START, 8'($urandom), NO_KAT);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 99) < 5)
                        send_req(REQ_UNUSED, 8'($urandom), NO_KAT);
                    send_req(sha_pkg::REQ_DATA, 8'($urandom), NO_KAT);
                end
                if (!skip_finish) send_req(sha_pkg::REQ_FINISH, 8'($urandom), NO_KAT);
            end
        end

        drain();
        if (errors == 0 && digest_q.size() == 0)
            $display("sha1_sha256_hash_engine: match");
        else
            $display("sha1_sha256_hash_engine: mismatch");
        $finish;
    end

endmodule
